>>> design/aesctr_pkg.sv
// shared types, constants and cipher functions for the aes-128 counter mode block
// no dependencies
package aesctr_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;
	localparam logic [1:0] REG_NONCE    = 2'd2;

	localparam int unsigned ROUNDS = 10;

	typedef struct packed {
		logic [63:0] data_high;
		logic [63:0] data_low;
		logic [63:0] block_index;
		logic [4:0]  valid_bytes;
		logic        final_block;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
		logic [4:0]  result_bytes;
		logic        result_final;
	} out_word_t;

	// one item in flight: cipher state plus the data riding along
	typedef struct packed {
		logic [127:0] state;
		logic [127:0] data;
		logic [4:0]   bytes;
		logic         fin;
	} stage_t;

	typedef logic [ROUNDS:0][127:0] rk_set_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// multiply by x in gf(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// subbytes then shiftrows, byte i sits at bits 127-8i
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (c * 4 + r) -: 8] = SBOX[s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return t;
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		unique case (r)
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h04;
			4'd4:    v = 8'h08;
			4'd5:    v = 8'h10;
			4'd6:    v = 8'h20;
			4'd7:    v = 8'h40;
			4'd8:    v = 8'h80;
			4'd9:    v = 8'h1b;
			4'd10:   v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// one step of the key schedule
	function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
		logic [127:0] n;
		n = '0;
		n[127:120] = k[127:120] ^ SBOX[k[23:16]] ^ rc;
		n[119:112] = k[119:112] ^ SBOX[k[15:8]];
		n[111:104] = k[111:104] ^ SBOX[k[7:0]];
		n[103:96]  = k[103:96]  ^ SBOX[k[31:24]];
		for (int i = 4; i < 16; i++) begin
			n[127 - 8 * i -: 8] = k[127 - 8 * i -: 8] ^ n[127 - 8 * (i - 4) -: 8];
		end
		return n;
	endfunction

endpackage

>>> design/aes128_ctr_keystream_xor.sv
// top level of the aes-128 counter mode keystream xor engine
// depends on aesctr_pkg, aesctr_keyexp, aesctr_round
//
// usage:
//  src channel (src_valid, src_stall, src_word) takes one 16-byte block with
//  its block index; a word moves when valid is high and stall is low.
//  dst channel (dst_valid, dst_stall, dst_word) gives the xored block.
//  cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes key_high,
//  key_low or the nonce; cfg_ready is always high. write only while idle.
//  the pipeline has the initial key add, ten round stages and an output stage.
//  throughput is one word per cycle while src_stall is low, one round per stage.
//  every stage holds its own valid bit, so bubbles close up while dst stalls
//  and the block keeps taking words until the pipeline is full.
//  after reset and after each key write the key schedule runs, one round key
//  per cycle, and src_stall stays high meanwhile.
//  reset clears the config registers, valid bits and schedule counter and expands the all-zero key.
module aes128_ctr_keystream_xor import aesctr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  in_word_t    src_word,
	output logic        dst_valid,
	input  logic        dst_stall,
	output out_word_t   dst_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_high_q, key_low_q, nonce_q;
	logic        start_q;
	logic        busy;
	rk_set_t     rk;

	logic        valid_s [ROUNDS+1];
	stage_t      word_s  [ROUNDS+1];
	logic        ready_s [ROUNDS+2];
	logic        accept;

	logic        valid_so;
	out_word_t   word_so;
	logic [127:0] result;
	logic [4:0]  cnt;

	assign cfg_ready = 1'b1;

	// configuration registers and key schedule start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			nonce_q    <= '0;
			start_q    <= 1'b1;
		end else begin
			start_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_KEY_HIGH: begin
						key_high_q <= cfg_data;
						start_q    <= 1'b1;
					end
					REG_KEY_LOW: begin
						key_low_q <= cfg_data;
						start_q   <= 1'b1;
					end
					REG_NONCE: nonce_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	aesctr_keyexp u_keyexp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.key    ({key_high_q, key_low_q}),
		.busy   (busy),
		.rk     (rk)
	);

	// input stage: counter block and initial key add
	assign src_stall = busy || !ready_s[0];
	assign accept    = src_valid && !src_stall;
	assign ready_s[0] = !valid_s[0] || ready_s[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (ready_s[0]) begin
			valid_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s[0].state <= {nonce_q, src_word.block_index} ^ rk[0];
			word_s[0].data  <= {src_word.data_high, src_word.data_low};
			word_s[0].bytes <= src_word.valid_bytes;
			word_s[0].fin   <= src_word.final_block;
		end
	end

	// round stages
	for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
		aesctr_round u_round (
			.clk        (clk),
			.arst_n     (arst_n),
			.last_round (r == ROUNDS),
			.rk         (rk[r]),
			.up_valid   (valid_s[r-1]),
			.up_word    (word_s[r-1]),
			.up_ready   (ready_s[r]),
			.dn_valid   (valid_s[r]),
			.dn_word    (word_s[r]),
			.dn_ready   (ready_s[r+1])
		);
	end

	// output stage: keystream xor and byte mask
	assign ready_s[ROUNDS+1] = !valid_so || !dst_stall;
	assign cnt = (word_s[ROUNDS].bytes > 5'd16) ? 5'd16 : word_s[ROUNDS].bytes;

	always_comb begin
		result = word_s[ROUNDS].state ^ word_s[ROUNDS].data;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) >= cnt) begin
				result[127 - 8 * i -: 8] = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_so <= 1'b0;
		end else if (ready_s[ROUNDS+1]) begin
			valid_so <= valid_s[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s[ROUNDS+1] && valid_s[ROUNDS]) begin
			word_so.result_high  <= result[127:64];
			word_so.result_low   <= result[63:0];
			word_so.result_bytes <= word_s[ROUNDS].bytes;
			word_so.result_final <= word_s[ROUNDS].fin;
		end
	end

	assign dst_valid = valid_so;
	assign dst_word  = word_so;

endmodule

>>> design/aesctr_keyexp.sv
// iterative key schedule: one round key per cycle into a register set
// depends on aesctr_pkg
module aesctr_keyexp import aesctr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] key,
	output logic         busy,
	output rk_set_t      rk
);

	rk_set_t      rk_q;
	logic [127:0] cur_q;
	logic [3:0]   cnt_q;
	logic [127:0] nxt;

	assign nxt  = key_step(cur_q, rcon(cnt_q));
	assign busy = start || (cnt_q != 4'd0);
	assign rk   = rk_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (start) begin
			cnt_q <= 4'd1;
		end else if (cnt_q == 4'(ROUNDS)) begin
			cnt_q <= 4'd0;
		end else if (cnt_q != 4'd0) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	// round key registers
	always_ff @(posedge clk) begin
		if (start) begin
			cur_q    <= key;
			rk_q[0]  <= key;
		end else if (cnt_q != 4'd0) begin
			cur_q       <= nxt;
			rk_q[cnt_q] <= nxt;
		end
	end

endmodule

>>> design/aesctr_round.sv
// one cipher round as a pipeline stage with its own valid bit
// depends on aesctr_pkg
module aesctr_round import aesctr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         last_round,
	input  logic [127:0] rk,
	input  logic         up_valid,
	input  stage_t       up_word,
	output logic         up_ready,
	output logic         dn_valid,
	output stage_t       dn_word,
	input  logic         dn_ready
);

	logic   valid_s1;
	stage_t word_s1;
	logic [127:0] shifted;
	logic [127:0] mixed;

	assign shifted  = sub_shift(up_word.state);
	assign mixed    = last_round ? shifted : mix_columns(shifted);
	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1.state <= mixed ^ rk;
			word_s1.data  <= up_word.data;
			word_s1.bytes <= up_word.bytes;
			word_s1.fin   <= up_word.fin;
		end
	end

endmodule

>>> design/aesctr_checker.sv
// port-level checks for the counter mode engine, bound to the top level
// depends on aesctr_pkg and aes128_ctr_keystream_xor
module aesctr_checker import aesctr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        src_stall,
	input logic        dst_valid,
	input logic        dst_stall,
	input out_word_t   dst_word,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index
);

	// a held result keeps its word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_word))
		else $error("stalled result changed");

	// a key write blocks input while the schedule runs
	a_key_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW)
		|=> src_stall ##1 src_stall)
		else $error("input taken during key schedule");

	// zero byte count clears the whole result
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_word.result_bytes == 5'd0
		|-> dst_word.result_high == 64'd0 && dst_word.result_low == 64'd0)
		else $error("unmasked bytes with zero count");

	// short block leaves the low half empty
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_word.result_bytes <= 5'd8 |-> dst_word.result_low == 64'd0)
		else $error("bytes past count not cleared");

endmodule

bind aes128_ctr_keystream_xor aesctr_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_stall (src_stall),
	.dst_valid (dst_valid),
	.dst_stall (dst_stall),
	.dst_word  (dst_word),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index)
);
